### rtl/core/hbps_pkg.sv
// Heart-rate monitor broadcast page scheduler: shared types and constants.
// No dependencies; imported by the hbps_* modules and the top level.
`default_nettype none

package hbps_pkg;

  // Payload geometry
  localparam int unsigned NumBytes = 8;
  localparam int unsigned MsgCntW  = 7;
  localparam int unsigned BgPageW  = 3;
  localparam int unsigned ToggleW  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OpTimeW  = 24;

  // Request function codes
  localparam logic FuncTransmit = 1'b0;
  localparam logic FuncUpdate   = 1'b1;

  // Page numbers
  localparam logic [BgPageW-1:0] PageOpTime  = 3'd1;
  localparam logic [BgPageW-1:0] PageMfr     = 3'd2;
  localparam logic [BgPageW-1:0] PageProduct = 3'd3;
  localparam logic [BgPageW-1:0] PageMain    = 3'd4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgMfrId   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSerial  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHwVer   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSwVer   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgModel   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPeriod  = 3'd5;

  // Register reset values
  localparam logic [7:0]  RstMfrId  = 8'd2;
  localparam logic [15:0] RstSerial = 16'd43981;
  localparam logic [7:0]  RstHwVer  = 8'd0;
  localparam logic [7:0]  RstSwVer  = 8'd0;
  localparam logic [7:0]  RstModel  = 8'd2;
  localparam logic [15:0] RstPeriod = 16'd246;

  // floor(t * 1024 / 1000) = (t * ceil(2^30 / 125)) >> 23 for 16-bit t
  localparam logic [23:0] Recip1024  = 24'd8589935;
  localparam int unsigned Shift1024  = 23;
  // floor(ms / 2000) = ((ms >> 4) * ceil(2^35 / 125)) >> 35 for 32-bit ms
  localparam logic [28:0] RecipOpTime = 29'd274877907;
  localparam int unsigned ShiftOpTime = 35;

  typedef logic [7:0] byte_t;
  typedef byte_t [NumBytes-1:0] payload_t;

  typedef struct packed {
    logic        func;
    logic [15:0] prev_event_time_ms;
    logic [15:0] event_time_ms;
    logic [7:0]  heart_rate;
  } item_t;

  typedef struct packed {
    logic [7:0]  mfr_id;
    logic [15:0] serial;
    logic [7:0]  hw_ver;
    logic [7:0]  sw_ver;
    logic [7:0]  model;
    logic [15:0] period;
  } cfg_t;

  typedef struct packed {
    logic        wr;
    logic [15:0] value;
  } period_wr_t;

  // Processing-stage strobe shared by the state holders
  typedef struct packed {
    logic fire;
    logic tx;
  } step_t;

endpackage

`default_nettype wire

### rtl/core/hbps_in_if.sv
// Input request channel of the page scheduler: valid/ready plus item fields.
// Depends on nothing.
`default_nettype none

interface hbps_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] prev_event_time_ms;
  logic [15:0] event_time_ms;
  logic [7:0]  heart_rate;

  modport source (output valid, func, prev_event_time_ms, event_time_ms, heart_rate,
                  input ready);
  modport sink   (input valid, func, prev_event_time_ms, event_time_ms, heart_rate,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/hbps_out_if.sv
// Output payload channel of the page scheduler: valid/ready plus eight bytes.
// Depends on nothing.
`default_nettype none

interface hbps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;
  logic [7:0] byte6;
  logic [7:0] byte7;

  modport source (output valid, byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
                  input ready);
  modport sink   (input valid, byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/hbps_cfg_if.sv
// Register write channel of the page scheduler: valid/ready, index and data.
// Depends on nothing.
`default_nettype none

interface hbps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/hbps_cfg_regs.sv
// Identity and period registers of the page scheduler.
// Depends on hbps_pkg.
`default_nettype none

module hbps_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [hbps_pkg::CfgIdxW-1:0]  wr_index_i,
  input  wire logic [hbps_pkg::CfgDataW-1:0] wr_data_i,
  output hbps_pkg::cfg_t                     cfg_o,
  output hbps_pkg::period_wr_t               period_wr_o
);
  import hbps_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        CfgMfrId:  cfg_d.mfr_id = wr_data_i[7:0];
        CfgSerial: cfg_d.serial = wr_data_i;
        CfgHwVer:  cfg_d.hw_ver = wr_data_i[7:0];
        CfgSwVer:  cfg_d.sw_ver = wr_data_i[7:0];
        CfgModel:  cfg_d.model  = wr_data_i[7:0];
        CfgPeriod: cfg_d.period = wr_data_i;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mfr_id: RstMfrId, serial: RstSerial, hw_ver: RstHwVer,
                 sw_ver: RstSwVer, model: RstModel, period: RstPeriod};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o             = cfg_q;
  assign period_wr_o.wr    = wr_en_i && (wr_index_i == CfgPeriod);
  assign period_wr_o.value = wr_data_i;

endmodule

`default_nettype wire

### rtl/core/hbps_ms_conv.sv
// Converts a millisecond time to 1/1024 s units, saturating at 16 bits.
// Depends on hbps_pkg.
`default_nettype none

module hbps_ms_conv (
  input  wire logic [15:0] time_ms_i,
  output      logic [15:0] time_1024_o
);
  import hbps_pkg::*;

  logic [39:0] prod;
  logic [16:0] quot;

  // Multiply by the reciprocal of 125 with the x128 folded into the shift
  assign prod        = time_ms_i * Recip1024;
  assign quot        = prod[Shift1024 +: 17];
  assign time_1024_o = quot[16] ? 16'hFFFF : quot[15:0];

endmodule

`default_nettype wire

### rtl/core/hbps_optime.sv
// Operating-time tracker: keeps events*period for the next transmit and
// divides it by 2000. Depends on hbps_pkg.
`default_nettype none

module hbps_optime (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire hbps_pkg::step_t              step_i,
  input  wire hbps_pkg::period_wr_t         period_wr_i,
  input  wire logic [15:0]                  period_i,
  output      logic [hbps_pkg::OpTimeW-1:0] op_time_o
);
  import hbps_pkg::*;

  // Event count and elapsed ms as they will be after the next transmit
  logic [31:0] ev_q, ev_d;
  logic [31:0] ms_q, ms_d;
  logic [47:0] prod_wr;
  logic [56:0] prod_div;

  assign prod_wr = ev_q * period_wr_i.value;

  // Advance on every transmit; rebuild the product on a period write
  always_comb begin
    ev_d = ev_q;
    ms_d = ms_q;
    if (step_i.fire && step_i.tx) begin
      ev_d = ev_q + 32'd1;
      ms_d = ms_q + {16'd0, period_i};
    end
    if (period_wr_i.wr) begin
      ms_d = prod_wr[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= 32'd1;
      ms_q <= {16'd0, RstPeriod};
    end else begin
      ev_q <= ev_d;
      ms_q <= ms_d;
    end
  end

  // Divide by 16, then by 125 through the reciprocal
  assign prod_div  = ms_q[31:4] * RecipOpTime;
  assign op_time_o = {2'b00, prod_div[ShiftOpTime +: 22]};

endmodule

`default_nettype wire

### rtl/core/hbps_page_core.sv
// Payload store and page rotation state; builds the next payload.
// Depends on hbps_pkg.
`default_nettype none

module hbps_page_core #(
  parameter int unsigned BACKGROUND_INTERVAL = 65
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire hbps_pkg::step_t              step_i,
  input  wire hbps_pkg::item_t              item_i,
  input  wire hbps_pkg::cfg_t               cfg_i,
  input  wire logic [hbps_pkg::OpTimeW-1:0] op_time_i,
  input  wire logic [15:0]                  prev_1024_i,
  input  wire logic [15:0]                  cur_1024_i,
  output hbps_pkg::payload_t                payload_o
);
  import hbps_pkg::*;

  localparam logic [MsgCntW-1:0] Interval = MsgCntW'(BACKGROUND_INTERVAL);

  payload_t             store_q, store_d;
  logic [MsgCntW-1:0]   mc_q, mc_d, mc_inc;
  logic [BgPageW-1:0]   bg_q, bg_d, page_sel;
  logic [ToggleW-1:0]   tg_q, tg_d;

  assign mc_inc   = mc_q + MsgCntW'(1);
  // Out-of-rotation page values fall back to the operating-time page
  assign page_sel = ((bg_q == PageOpTime) || (bg_q == PageMfr) || (bg_q == PageProduct))
                    ? bg_q : PageOpTime;

  // Apply one request to the store
  always_comb begin
    store_d = store_q;
    mc_d    = mc_q;
    bg_d    = bg_q;
    tg_d    = tg_q;
    if (step_i.fire) begin
      if (!step_i.tx) begin
        store_d[2] = prev_1024_i[7:0];
        store_d[3] = prev_1024_i[15:8];
        store_d[4] = cur_1024_i[7:0];
        store_d[5] = cur_1024_i[15:8];
        store_d[6] = store_q[6] + 8'd1;
        store_d[7] = item_i.heart_rate;
      end else begin
        if (mc_inc == Interval) begin
          mc_d       = '0;
          store_d[0] = {5'd0, page_sel};
          case (page_sel)
            PageOpTime: begin
              store_d[1] = op_time_i[7:0];
              store_d[2] = op_time_i[15:8];
              store_d[3] = op_time_i[23:16];
            end
            PageMfr: begin
              store_d[1] = cfg_i.mfr_id;
              store_d[2] = cfg_i.serial[7:0];
              store_d[3] = cfg_i.serial[15:8];
            end
            default: begin
              store_d[1] = cfg_i.hw_ver;
              store_d[2] = cfg_i.sw_ver;
              store_d[3] = cfg_i.model;
            end
          endcase
          bg_d = page_sel + BgPageW'(1);
        end else begin
          mc_d       = mc_inc;
          store_d[0] = {5'd0, PageMain};
        end
        tg_d          = tg_q + ToggleW'(1);
        store_d[0][7] = tg_d[ToggleW-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      mc_q    <= '0;
      bg_q    <= PageOpTime;
      tg_q    <= '0;
    end else begin
      store_q <= store_d;
      mc_q    <= mc_d;
      bg_q    <= bg_d;
      tg_q    <= tg_d;
    end
  end

  assign payload_o = store_d;

  // Message count wraps before reaching the interval
  a_mc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mc_q < Interval) else $error("message count reached interval");

  // Toggle phase advances once per transmit
  a_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.fire && step_i.tx |=> tg_q == $past(tg_q) + ToggleW'(1))
    else $error("toggle phase did not advance");

  // Background page pointer is never zero
  a_bg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bg_q != '0) else $error("background page pointer is zero");

endmodule

`default_nettype wire

### rtl/core/hrm_broadcast_page_scheduler.sv
// Top level of the heart-rate monitor broadcast page scheduler.
// Depends on hbps_pkg, the three channel interfaces and the hbps_* modules.
//
//   Channel  Dir  Handshake     Payload
//   in_ch    in   valid/ready   func, prev_event_time_ms, event_time_ms, heart_rate
//   out_ch   out  valid/ready   byte0 .. byte7
//   cfg_ch   in   valid/ready   index (3 b), data (16 b); ready is always high
//
// One request per cycle sustained while out_ch is not stalled. A request is held
// in the input register; a transmit's payload is then loaded into the output
// register once the output is free, and out_ch.valid rises with it. Updates
// produce no payload.
// Reset clears the payload store and counters at once; no sweep is needed.
// A stalled payload holds the output register; the input register still
// accepts one request, and updates keep flowing past a full output.
`default_nettype none

module hrm_broadcast_page_scheduler #(
  parameter int unsigned BACKGROUND_INTERVAL = 65
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  hbps_in_if.sink    in_ch,
  hbps_out_if.source out_ch,
  hbps_cfg_if.sink   cfg_ch
);
  import hbps_pkg::*;

  item_t      in_item_q;
  logic       in_valid_q;
  payload_t   out_q;
  logic       out_valid_q;
  payload_t   payload;
  step_t      step;
  cfg_t       cfg;
  period_wr_t period_wr;
  logic       out_free;
  logic       proc_ok;
  logic       in_fire;
  logic [OpTimeW-1:0] op_time;
  logic [15:0] prev_1024, cur_1024;

  // Handshake control
  assign out_free  = !out_valid_q || out_ch.ready;
  assign proc_ok   = in_valid_q && ((in_item_q.func == FuncUpdate) || out_free);
  assign in_ch.ready = !in_valid_q || proc_ok;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign step.fire = proc_ok;
  assign step.tx   = (in_item_q.func == FuncTransmit);
  assign cfg_ch.ready = 1'b1;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q <= '{func: in_ch.func, prev_event_time_ms: in_ch.prev_event_time_ms,
                     event_time_ms: in_ch.event_time_ms, heart_rate: in_ch.heart_rate};
    end
  end

  hbps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (cfg_ch.valid),
    .wr_index_i  (cfg_ch.index),
    .wr_data_i   (cfg_ch.data),
    .cfg_o       (cfg),
    .period_wr_o (period_wr)
  );

  hbps_ms_conv u_conv_prev (
    .time_ms_i   (in_item_q.prev_event_time_ms),
    .time_1024_o (prev_1024)
  );

  hbps_ms_conv u_conv_cur (
    .time_ms_i   (in_item_q.event_time_ms),
    .time_1024_o (cur_1024)
  );

  hbps_optime u_optime (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .period_wr_i (period_wr),
    .period_i    (cfg.period),
    .op_time_o   (op_time)
  );

  hbps_page_core #(
    .BACKGROUND_INTERVAL (BACKGROUND_INTERVAL)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_item_q),
    .cfg_i       (cfg),
    .op_time_i   (op_time),
    .prev_1024_i (prev_1024),
    .cur_1024_i  (cur_1024),
    .payload_o   (payload)
  );

  // Output register: load on transmit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step.fire && step.tx) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.fire && step.tx) begin
      out_q <= payload;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.byte0 = out_q[0];
  assign out_ch.byte1 = out_q[1];
  assign out_ch.byte2 = out_q[2];
  assign out_ch.byte3 = out_q[3];
  assign out_ch.byte4 = out_q[4];
  assign out_ch.byte5 = out_q[5];
  assign out_ch.byte6 = out_q[6];
  assign out_ch.byte7 = out_q[7];

  // A transmit always leaves a payload in the output register
  a_tx_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.fire && step.tx |=> out_valid_q) else $error("transmit lost its payload");

  // An update never creates a payload on an empty output
  a_upd_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.fire && !step.tx && !out_valid_q |=> !out_valid_q)
    else $error("update produced a payload");

  // A held request in the input register is never overwritten
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !proc_ok |=> in_valid_q && $stable(in_item_q))
    else $error("pending request overwritten");

endmodule

`default_nettype wire
